FILE: rtl/b64c_pkg.sv
// Package for the base64 codec: beat types, state and burst types, alphabet helpers.
`default_nettype none

package b64c_pkg;

    // Fixed codes and constants
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;
    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // Input beat payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_item;
    } in_beat_t;

    // Output beat payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_message;
    } out_beat_t;

    // Group state carried between items
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
        logic        stopped;
    } group_state_t;

    // Results caused by one item, played out one beat per cycle while dst does not stall
    typedef struct packed {
        logic            present;
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            data_ok;
        logic            eom;
    } burst_t;

    // Map a sextet to its alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] sextet);
        logic [7:0] s;
        s = {2'b00, sextet};
        if (sextet < 6'd26)
            return 8'h41 + s;
        else if (sextet < 6'd52)
            return 8'h61 + s - 8'd26;
        else if (sextet < 6'd62)
            return 8'h30 + s - 8'd52;
        else if (sextet == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    // Map a character to {in_alphabet, sextet}
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A)
            v = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            v = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30 + 8'd52;
        else if (c == 8'h2B)
            v = 8'd62;
        else if (c == 8'h2F)
            v = 8'd63;
        else
            return 7'h00;
        return {1'b1, v[5:0]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/b64c_step.sv
// Next-state and result-burst logic for one item of the base64 codec.
`default_nettype none

module b64c_step
    import b64c_pkg::*;
(
    input  wire logic         direction,
    input  wire in_beat_t     item,
    input  wire group_state_t cur,
    output group_state_t      nxt,
    output burst_t            burst
);

    logic [23:0] ebits;
    logic [23:0] epad;
    logic [1:0]  ecnt;
    logic [6:0]  dv;
    logic [23:0] nbits;
    logic [23:0] tbits;
    logic        full;

    always_comb
    begin
        nxt   = cur;
        burst = '0;
        ebits = {cur.bits[15:0], item.data_byte};
        ecnt  = cur.count + 2'd1;
        epad  = '0;
        dv    = dec_char(item.data_byte);
        nbits = {cur.bits[17:0], dv[5:0]};
        tbits = '0;
        full  = 1'b0;

        if (direction == DIR_ENCODE)
        begin
            // Gather bytes; a full group gives four characters
            if (ecnt == 2'd3)
            begin
                for (int k = 0; k < 4; k++)
                    burst.bytes[k] = enc_char(ebits[23 - 6 * k -: 6]);
                burst.present  = 1'b1;
                burst.data_ok  = 1'b1;
                burst.last_idx = 2'd3;
                burst.eom      = item.final_item;
                nxt.bits       = '0;
                nxt.count      = '0;
            end
            else
            begin
                nxt.bits  = ebits;
                nxt.count = ecnt;
                // Flush a partial group with padding
                if (item.final_item)
                begin
                    epad = (ecnt == 2'd1) ? {ebits[7:0], 16'h0000} : {ebits[15:0], 8'h00};
                    for (int k = 0; k < 4; k++)
                        burst.bytes[k] = (k <= int'(ecnt)) ?
                                         enc_char(epad[23 - 6 * k -: 6]) : PAD_CHAR;
                    burst.present  = 1'b1;
                    burst.data_ok  = 1'b1;
                    burst.last_idx = 2'd3;
                    burst.eom      = 1'b1;
                end
            end
        end
        else
        begin
            // Take a character unless decoding has stopped
            if (!cur.stopped)
            begin
                if (!dv[6])
                    nxt.stopped = 1'b1;
                else if (cur.count == 2'd3)
                begin
                    full           = 1'b1;
                    burst.bytes[0] = nbits[23:16];
                    burst.bytes[1] = nbits[15:8];
                    burst.bytes[2] = nbits[7:0];
                    burst.present  = 1'b1;
                    burst.data_ok  = 1'b1;
                    burst.last_idx = 2'd2;
                    burst.eom      = item.final_item;
                    nxt.bits       = '0;
                    nxt.count      = '0;
                end
                else
                begin
                    nxt.bits  = nbits;
                    nxt.count = cur.count + 2'd1;
                end
            end
            // Flush the tail, or give an empty end marker
            if (item.final_item && !full)
            begin
                burst.present = 1'b1;
                burst.eom     = 1'b1;
                if (nxt.count == 2'd3)
                begin
                    tbits          = {nxt.bits[17:0], 6'b000000};
                    burst.bytes[0] = tbits[23:16];
                    burst.bytes[1] = tbits[15:8];
                    burst.data_ok  = 1'b1;
                    burst.last_idx = 2'd1;
                end
                else if (nxt.count == 2'd2)
                begin
                    tbits          = {nxt.bits[11:0], 12'h000};
                    burst.bytes[0] = tbits[23:16];
                    burst.data_ok  = 1'b1;
                    burst.last_idx = 2'd0;
                end
            end
        end

        // Clear the group after the last item of a message
        if (item.final_item)
            nxt = '0;
    end

endmodule

`default_nettype wire

FILE: rtl/base64_codec_unit.sv
// Top level of the streaming base64 codec: group state, burst register and output sequencer.
`default_nettype none

// Streaming base64 (standard alphabet) encoder/decoder. cfg_wr_en/cfg_wr_data set the
// direction (0 encode, 1 decode) and clear the group state; a loaded burst still plays out.
// Each accepted src beat updates the group state in the same cycle. It also loads the
// results it causes (none to four) into a burst register, and the dst side plays that
// register out one beat per cycle while dst_stall is low, starting the cycle after the
// accept. A src beat that causes no result is taken in any cycle, even while a burst plays
// out. A src beat that causes results waits for the cycle in which the last beat of the
// previous burst leaves. So an item that neither closes a group nor ends a message is never
// held. An item that does is held until the burst ahead of it is gone. Encoding is bound by
// the single dst port. Decoding takes one character per cycle while dst_stall is low.
module base64_codec_unit
    import b64c_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire in_beat_t  src_data,
    output logic           dst_valid,
    input  wire logic      dst_stall,
    output out_beat_t      dst_data
);

    logic         direction_reg;
    group_state_t state_reg;
    group_state_t state_next;
    burst_t       burst_next;
    burst_t       burst_reg;
    logic         busy_reg;
    logic [1:0]   idx_reg;
    logic         take;
    logic         last_beat;
    logic         accept;

    b64c_step u_step (
        .direction (direction_reg),
        .item      (src_data),
        .cur       (state_reg),
        .nxt       (state_next),
        .burst     (burst_next)
    );

    // Handshake on both sides; hold only a beat whose results would collide with the burst
    assign take      = busy_reg && !dst_stall;
    assign last_beat = idx_reg == burst_reg.last_idx;
    assign src_stall = busy_reg && burst_next.present && !(take && last_beat);
    assign accept    = src_valid && !src_stall;

    // Hold direction and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            state_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            direction_reg <= cfg_wr_data;
            state_reg     <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Load a burst, then advance one beat per take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (accept && burst_next.present)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take && last_beat)
        begin
            busy_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Burst payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept && burst_next.present)
            burst_reg <= burst_next;
    end

    // Drive the output beat
    assign dst_valid               = busy_reg;
    assign dst_data.out_byte       = burst_reg.bytes[idx_reg];
    assign dst_data.byte_valid     = burst_reg.data_ok;
    assign dst_data.end_of_message = burst_reg.eom && last_beat;

endmodule

`default_nettype wire
